FILE: sv/char_lcd_number_field_writer_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the character LCD number field writer
// Property macros that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NUMBER_FIELD_WRITER_CORE_DEFINES_SVH
`define CHAR_LCD_NUMBER_FIELD_WRITER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define LCDNF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcdnf check failed");

// antecedent implies consequent in the next cycle
`define LCDNF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lcdnf check failed");

`else

`define LCDNF_ASSERT_SAME(label, clk, rst, ante, cons)
`define LCDNF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: sv/lcdnf_pkg.sv
// ----------------------------------------------------------------------------
// lcdnf_pkg
// Types, codes and constants shared by the number field writer.
// ----------------------------------------------------------------------------
package lcdnf_pkg;

   localparam int VALUE_W     = 16;
   localparam int DIGIT_W     = 4;
   localparam int NUM_DIGITS  = 5;
   localparam int BCD_W       = NUM_DIGITS * DIGIT_W;
   localparam int NUM_STEPS   = VALUE_W;
   localparam int NUM_CHARS   = 8;
   localparam int NUM_NIBBLES = 2 * NUM_CHARS + 2;
   localparam int IDX_W       = $clog2(NUM_NIBBLES);
   localparam int CHAR_IDX_W  = $clog2(NUM_CHARS);

   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_SPACE = 8'h20;
   localparam logic [DIGIT_W-1:0] DIGIT_ADJ_MIN = 4'd5;
   localparam logic [DIGIT_W-1:0] DIGIT_ADJ     = 4'd3;

   typedef enum logic [1:0] {
      KIND_BIN  = 2'd0,
      KIND_DEC3 = 2'd1,
      KIND_DEC5 = 2'd2,
      KIND_BAD  = 2'd3
   } kind_type;

   typedef struct packed {
      logic               valid;
      logic [7:0]         position;
      kind_type           kind;
      logic [7:0]         lo;
      logic [VALUE_W-1:0] bin;
      logic [BCD_W-1:0]   bcd;
   } cell_type;

   // one shift-and-add-3 step of binary to BCD conversion
   function automatic cell_type dd_step(cell_type c);
      cell_type         r;
      logic [BCD_W-1:0] adj;
      int               k;
      r   = c;
      adj = c.bcd;
      for (k = 0; k < NUM_DIGITS; k++) begin
         if (adj[k*DIGIT_W +: DIGIT_W] >= DIGIT_ADJ_MIN) begin
            adj[k*DIGIT_W +: DIGIT_W] = adj[k*DIGIT_W +: DIGIT_W] + DIGIT_ADJ;
         end
      end
      r.bcd = {adj[BCD_W-2:0], c.bin[VALUE_W-1]};
      r.bin = {c.bin[VALUE_W-2:0], 1'b0};
      return r;
   endfunction

endpackage

FILE: sv/lcdnf_req_if.sv
// ----------------------------------------------------------------------------
// lcdnf_req_if
// Request channel: one field update per transfer.
// ----------------------------------------------------------------------------
interface lcdnf_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  position;
   logic [15:0] value;
   logic [1:0]  kind;

   modport source (output valid, output position, output value, output kind, input ready);
   modport sink   (input valid, input position, input value, input kind, output ready);
endinterface

FILE: sv/lcdnf_rsp_if.sv
// ----------------------------------------------------------------------------
// lcdnf_rsp_if
// Response channel: one LCD bus nibble write per transfer.
// ----------------------------------------------------------------------------
interface lcdnf_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] nibble;
   logic       is_data;
   logic       last;

   modport source (output valid, output nibble, output is_data, output last, input ready);
   modport sink   (input valid, input nibble, input is_data, input last, output ready);
endinterface

FILE: sv/char_lcd_number_field_writer_core.sv
// ----------------------------------------------------------------------------
// char_lcd_number_field_writer_core
// Formats a 16-bit number into an eight-character LCD field and emits it as
// 4-bit bus writes.
// ----------------------------------------------------------------------------
// Each request carries a set-address command byte, a value and a format kind.
// A valid request yields eighteen response transfers: the position byte as a
// command (is_data low), then eight characters as data, high nibble first,
// with last set on the eighteenth. Kind 3 is taken and yields nothing. The
// number passes through a row of sixteen conversion cells, one binary to BCD
// step each, registered cell by cell before the nibble sender takes it. The
// nibble sender issues one write per cycle while the receiver holds ready;
// further requests queue in the cell row while a field is being sent.
// ----------------------------------------------------------------------------
module char_lcd_number_field_writer_core (
   input  logic        clock,
   input  logic        reset,
   lcdnf_req_if.sink   req_chan,
   lcdnf_rsp_if.source rsp_chan
);

   lcdnf_pkg::cell_type chain [lcdnf_pkg::NUM_STEPS+1];
   logic                take  [lcdnf_pkg::NUM_STEPS+1];
   lcdnf_pkg::cell_type head;
   logic                load;

   always_comb begin
      head.valid    = req_chan.valid &
                      (lcdnf_pkg::kind_type'(req_chan.kind) != lcdnf_pkg::KIND_BAD);
      head.position = req_chan.position;
      head.kind     = lcdnf_pkg::kind_type'(req_chan.kind);
      head.lo       = req_chan.value[7:0];
      head.bcd      = '0;
      if (lcdnf_pkg::kind_type'(req_chan.kind) == lcdnf_pkg::KIND_DEC5) begin
         head.bin = req_chan.value;
      end else begin
         head.bin = {8'd0, req_chan.value[7:0]};
      end
   end

   assign chain[0] = head;

   assign take[lcdnf_pkg::NUM_STEPS] = load;

   for (genvar i = 0; i < lcdnf_pkg::NUM_STEPS; i++) begin : g_cell
      assign take[i] = ~chain[i+1].valid | take[i+1];

      lcdnf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .take     (take[i]),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   assign req_chan.ready = take[0];

   lcdnf_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .tail     (chain[lcdnf_pkg::NUM_STEPS]),
      .load     (load),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: sv/lcdnf_cell.sv
// ----------------------------------------------------------------------------
// lcdnf_cell
// One conversion cell: applies one BCD step and registers the item.
// ----------------------------------------------------------------------------
module lcdnf_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  lcdnf_pkg::cell_type cell_in,
   output lcdnf_pkg::cell_type cell_out
);

   lcdnf_pkg::cell_type cell_ff;
   lcdnf_pkg::cell_type cell_in_step;

   assign cell_in_step = lcdnf_pkg::dd_step(cell_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.valid <= 1'b0;
      end else if (take) begin
         cell_ff.valid <= cell_in.valid;
      end
      if (take) begin
         cell_ff.position <= cell_in_step.position;
         cell_ff.kind     <= cell_in_step.kind;
         cell_ff.lo       <= cell_in_step.lo;
         cell_ff.bin      <= cell_in_step.bin;
         cell_ff.bcd      <= cell_in_step.bcd;
      end
   end

   assign cell_out = cell_ff;

endmodule

FILE: sv/lcdnf_emit.sv
// ----------------------------------------------------------------------------
// lcdnf_emit
// Formats eight characters and sends position and text as nibble writes.
// ----------------------------------------------------------------------------
`include "char_lcd_number_field_writer_core_defines.svh"

module lcdnf_emit (
   input  logic                clock,
   input  logic                reset,
   input  lcdnf_pkg::cell_type tail,
   output logic                load,
   lcdnf_rsp_if.source         rsp_chan
);

   localparam logic [lcdnf_pkg::IDX_W-1:0] IDX_LAST = lcdnf_pkg::IDX_W'(lcdnf_pkg::NUM_NIBBLES - 1);
   localparam logic [lcdnf_pkg::IDX_W-1:0] IDX_TEXT = lcdnf_pkg::IDX_W'(2);

   logic                          busy_ff;
   logic                          busy_in;
   logic [lcdnf_pkg::IDX_W-1:0]   idx_ff;
   logic [lcdnf_pkg::IDX_W-1:0]   idx_in;
   logic [7:0]                    pos_ff;
   logic [7:0]                    chars_ff [lcdnf_pkg::NUM_CHARS];
   logic [7:0]                    chars_in [lcdnf_pkg::NUM_CHARS];
   logic [lcdnf_pkg::IDX_W-1:0]   text_idx;
   logic [lcdnf_pkg::CHAR_IDX_W-1:0] char_sel;
   logic [7:0]                    cur_char;
   logic                          xfer;
   logic                          is_last;

   always_comb begin
      for (int i = 0; i < lcdnf_pkg::NUM_CHARS; i++) begin
         chars_in[i] = lcdnf_pkg::ASCII_SPACE;
         unique case (tail.kind)
            lcdnf_pkg::KIND_BIN: begin
               chars_in[i] = lcdnf_pkg::ASCII_ZERO | {7'd0, tail.lo[lcdnf_pkg::NUM_CHARS-1-i]};
            end
            lcdnf_pkg::KIND_DEC3: begin
               if (i < 3) begin
                  chars_in[i] = lcdnf_pkg::ASCII_ZERO |
                                {4'd0, tail.bcd[(2-i)*lcdnf_pkg::DIGIT_W +: lcdnf_pkg::DIGIT_W]};
               end
            end
            lcdnf_pkg::KIND_DEC5: begin
               if (i < lcdnf_pkg::NUM_DIGITS) begin
                  chars_in[i] = lcdnf_pkg::ASCII_ZERO |
                                {4'd0, tail.bcd[(lcdnf_pkg::NUM_DIGITS-1-i)*lcdnf_pkg::DIGIT_W
                                                +: lcdnf_pkg::DIGIT_W]};
               end
            end
            default: begin
               chars_in[i] = lcdnf_pkg::ASCII_SPACE;
            end
         endcase
      end
   end

   assign is_last = (idx_ff == IDX_LAST);
   assign xfer    = rsp_chan.valid & rsp_chan.ready;
   assign load    = ~busy_ff | (xfer & is_last);

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = tail.valid;
         idx_in  = '0;
      end else if (xfer) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pos_ff   <= tail.position;
         chars_ff <= chars_in;
      end
   end

   assign text_idx = idx_ff - IDX_TEXT;
   assign char_sel = text_idx[lcdnf_pkg::CHAR_IDX_W:1];
   assign cur_char = chars_ff[char_sel];

   always_comb begin
      rsp_chan.valid   = busy_ff;
      rsp_chan.last    = is_last;
      rsp_chan.is_data = (idx_ff >= IDX_TEXT);
      if (idx_ff < IDX_TEXT) begin
         rsp_chan.nibble = idx_ff[0] ? pos_ff[3:0] : pos_ff[7:4];
      end else begin
         rsp_chan.nibble = text_idx[0] ? cur_char[3:0] : cur_char[7:4];
      end
   end

   `LCDNF_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_chan.valid && !rsp_chan.ready, rsp_chan.valid && $stable(idx_ff))
   `LCDNF_ASSERT_SAME(a_cmd_first, clock, reset, rsp_chan.valid && !rsp_chan.is_data, idx_ff == '0 || idx_ff == 1)
   `LCDNF_ASSERT_NEXT(a_run_end, clock, reset, xfer && is_last && !tail.valid, !rsp_chan.valid)

endmodule

FILE: test/char_lcd_number_field_writer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_number_field_writer_core_test
// Self-checking bench for the LCD number field writer. A short table of
// directed field updates is followed by random ones. Every request transfer
// of a kind other than 3 is formatted into eighteen expected nibble writes,
// and each response transfer is compared field by field with the oldest one.
// Both channels idle at random, and the response side holds off once for a
// long stretch so that the conversion row fills and stalls the requests.
// ----------------------------------------------------------------------------
module char_lcd_number_field_writer_core_test;

   localparam int NUM_FIELDS   = 500;
   localparam int HOLD_AFTER   = 60;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 60;
   localparam int IDLE_LIMIT   = 4000;
   localparam int TEXT_W       = 8 * lcdnf_pkg::NUM_CHARS;

   typedef struct packed {
      logic [3:0] nibble;
      logic       is_data;
      logic       last;
   } lcd_write_type;

   typedef struct packed {
      logic [7:0]                    position;
      logic [lcdnf_pkg::VALUE_W-1:0] value;
      lcdnf_pkg::kind_type           kind;
      logic                          typed;
      logic [TEXT_W-1:0]             text;
   } field_req_type;

   logic clock;
   logic reset;

   lcdnf_req_if req_bus ();
   lcdnf_rsp_if rsp_bus ();

   char_lcd_number_field_writer_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   field_req_type stim_q[$];
   lcd_write_type nibble_writes_q[$];
   field_req_type cur_req;
   int            req_idx;
   int            req_gap;
   int            rsp_gap;
   logic          req_calm;
   logic          rsp_calm;
   logic          rsp_hold;
   int            errors;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic field_req_type field_row(logic [7:0] position, logic [15:0] value,
                                               lcdnf_pkg::kind_type kind, logic typed,
                                               logic [TEXT_W-1:0] text);
      field_req_type r;
      r.position = position;
      r.value    = value;
      r.kind     = kind;
      r.typed    = typed;
      r.text     = text;
      return r;
   endfunction

   function automatic logic [7:0] digit_char(int d);
      return lcdnf_pkg::ASCII_ZERO + 8'(d);
   endfunction

   function automatic logic [TEXT_W-1:0] field_text_for(logic [15:0] value,
                                                        lcdnf_pkg::kind_type kind);
      logic [TEXT_W-1:0] text;
      int lo;
      int v;
      int i;
      text = {lcdnf_pkg::NUM_CHARS{lcdnf_pkg::ASCII_SPACE}};
      lo   = int'(value[7:0]);
      v    = int'(value);
      case (kind)
         lcdnf_pkg::KIND_BIN: begin
            for (i = 0; i < lcdnf_pkg::NUM_CHARS; i++)
               text[TEXT_W-1-8*i -: 8] = digit_char(int'(value[7-i]));
         end
         lcdnf_pkg::KIND_DEC3: begin
            text[63 -: 8] = digit_char(lo / 100);
            text[55 -: 8] = digit_char((lo / 10) % 10);
            text[47 -: 8] = digit_char(lo % 10);
         end
         lcdnf_pkg::KIND_DEC5: begin
            text[63 -: 8] = digit_char(v / 10000);
            text[55 -: 8] = digit_char((v / 1000) % 10);
            text[47 -: 8] = digit_char((v / 100) % 10);
            text[39 -: 8] = digit_char((v / 10) % 10);
            text[31 -: 8] = digit_char(v % 10);
         end
         default: text = '0;
      endcase
      return text;
   endfunction

   function automatic void queue_byte(logic [7:0] b, logic is_data, logic fin);
      nibble_writes_q.push_back('{nibble: b[7:4], is_data: is_data, last: 1'b0});
      nibble_writes_q.push_back('{nibble: b[3:0], is_data: is_data, last: fin});
   endfunction

   function automatic void queue_field(field_req_type f);
      logic [TEXT_W-1:0] text;
      int i;
      if (f.kind == lcdnf_pkg::KIND_BAD) return;
      text = f.typed ? f.text : field_text_for(f.value, f.kind);
      queue_byte(f.position, 1'b0, 1'b0);
      for (i = 0; i < lcdnf_pkg::NUM_CHARS; i++)
         queue_byte(text[TEXT_W-1-8*i -: 8], 1'b1, i == lcdnf_pkg::NUM_CHARS - 1);
   endfunction

   function automatic int pick_gap(logic calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // request side: hold payload until transfer, then idle or offer the next
   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            queue_field(cur_req);
            if ($urandom_range(0, 39) == 0) req_calm = ~req_calm;
            req_gap = pick_gap(req_calm);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_bus.valid <= 1'b0;
            end else if (req_idx < stim_q.size()) begin
               cur_req = stim_q[req_idx];
               req_idx++;
               req_bus.valid    <= 1'b1;
               req_bus.position <= cur_req.position;
               req_bus.value    <= cur_req.value;
               req_bus.kind     <= cur_req.kind;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response side: check each transfer against the oldest expected write
   always @(posedge clock) begin
      lcd_write_type want;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (nibble_writes_q.size() == 0) begin
               $display("%0t: unexpected write: nibble %h is_data %b last %b", $time,
                        rsp_bus.nibble, rsp_bus.is_data, rsp_bus.last);
               errors++;
            end else begin
               want = nibble_writes_q.pop_front();
               if (rsp_bus.nibble !== want.nibble) begin
                  $display("%0t: nibble mismatch: expected %h, actual %h", $time,
                           want.nibble, rsp_bus.nibble);
                  errors++;
               end
               if (rsp_bus.is_data !== want.is_data) begin
                  $display("%0t: is_data mismatch: expected %b, actual %b", $time,
                           want.is_data, rsp_bus.is_data);
                  errors++;
               end
               if (rsp_bus.last !== want.last) begin
                  $display("%0t: last mismatch: expected %b, actual %b", $time,
                           want.last, rsp_bus.last);
                  errors++;
               end
            end
            if ($urandom_range(0, 199) == 0) rsp_calm = ~rsp_calm;
            rsp_gap = pick_gap(rsp_calm);
         end
         if (rsp_hold || rsp_gap > 0) begin
            if (rsp_gap > 0) rsp_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // long receiver hold-off while requests keep coming
   initial begin
      rsp_hold = 1'b0;
      while (req_idx < HOLD_AFTER) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      field_req_type r;
      reset            = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.position = '0;
      req_bus.value    = '0;
      req_bus.kind     = lcdnf_pkg::KIND_BIN;
      rsp_bus.ready    = 1'b0;
      req_idx          = 0;
      req_gap          = 0;
      rsp_gap          = 0;
      req_calm         = 1'b0;
      rsp_calm         = 1'b0;
      errors           = 0;

      stim_q.push_back(field_row(8'h80, 16'h0000, lcdnf_pkg::KIND_BIN,  1'b1, "00000000"));
      stim_q.push_back(field_row(8'hFF, 16'hFFFF, lcdnf_pkg::KIND_BIN,  1'b1, "11111111"));
      stim_q.push_back(field_row(8'h00, 16'hFF00, lcdnf_pkg::KIND_BIN,  1'b1, "00000000"));
      stim_q.push_back(field_row(8'h84, 16'h00AA, lcdnf_pkg::KIND_BIN,  1'b1, "10101010"));
      stim_q.push_back(field_row(8'hC0, 16'h3C55, lcdnf_pkg::KIND_BIN,  1'b0, '0));
      stim_q.push_back(field_row(8'h84, 16'h0000, lcdnf_pkg::KIND_DEC3, 1'b1, "000     "));
      stim_q.push_back(field_row(8'hC0, 16'h00FF, lcdnf_pkg::KIND_DEC3, 1'b1, "255     "));
      stim_q.push_back(field_row(8'h8A, 16'hFF64, lcdnf_pkg::KIND_DEC3, 1'b1, "100     "));
      stim_q.push_back(field_row(8'h01, 16'h1209, lcdnf_pkg::KIND_DEC3, 1'b0, '0));
      stim_q.push_back(field_row(8'hFE, 16'h0063, lcdnf_pkg::KIND_DEC3, 1'b0, '0));
      stim_q.push_back(field_row(8'h80, 16'h0000, lcdnf_pkg::KIND_DEC5, 1'b1, "00000   "));
      stim_q.push_back(field_row(8'hFF, 16'hFFFF, lcdnf_pkg::KIND_DEC5, 1'b1, "65535   "));
      stim_q.push_back(field_row(8'h00, 16'd60000, lcdnf_pkg::KIND_DEC5, 1'b1, "60000   "));
      stim_q.push_back(field_row(8'h94, 16'd59999, lcdnf_pkg::KIND_DEC5, 1'b0, '0));
      stim_q.push_back(field_row(8'hD4, 16'd9999,  lcdnf_pkg::KIND_DEC5, 1'b0, '0));
      stim_q.push_back(field_row(8'h88, 16'd12345, lcdnf_pkg::KIND_DEC5, 1'b1, "12345   "));
      stim_q.push_back(field_row(8'hFF, 16'hFFFF, lcdnf_pkg::KIND_BAD,  1'b1, '0));
      stim_q.push_back(field_row(8'h00, 16'h0000, lcdnf_pkg::KIND_BAD,  1'b1, '0));
      stim_q.push_back(field_row(8'h81, 16'h0001, lcdnf_pkg::KIND_BIN,  1'b0, '0));
      stim_q.push_back(field_row(8'h55, 16'h8000, lcdnf_pkg::KIND_BAD,  1'b1, '0));
      stim_q.push_back(field_row(8'hAA, 16'h8000, lcdnf_pkg::KIND_DEC5, 1'b0, '0));

      while (stim_q.size() < NUM_FIELDS) begin
         r.position = 8'($urandom_range(0, 255));
         r.kind     = ($urandom_range(0, 99) < 8)
                      ? lcdnf_pkg::KIND_BAD
                      : lcdnf_pkg::kind_type'($urandom_range(0, 2));
         case ($urandom_range(0, 9))
            0:       r.value = 16'h0000;
            1:       r.value = 16'hFFFF;
            2:       r.value = 16'($urandom_range(0, 255));
            3:       r.value = 16'($urandom_range(59990, 65535));
            4:       r.value = 16'($urandom_range(0, 9999));
            default: r.value = 16'($urandom);
         endcase
         r.typed = 1'b0;
         r.text  = '0;
         stim_q.push_back(r);
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (req_idx < stim_q.size() || req_bus.valid) @(posedge clock);
      while (nibble_writes_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0 && nibble_writes_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+sv
sv/lcdnf_pkg.sv
sv/lcdnf_req_if.sv
sv/lcdnf_rsp_if.sv
sv/lcdnf_cell.sv
sv/lcdnf_emit.sv
sv/char_lcd_number_field_writer_core.sv
test/char_lcd_number_field_writer_core_test.sv
